### rtl/core/lfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follow steering package
// Shared widths, register indexes, reset values and small helper functions.
// ----------------------------------------------------------------------------
package lfs_pkg;

    localparam int SensorW = 5;
    localparam int DutyW   = 8;
    localparam int AvgW    = 7;
    localparam int CountW  = 8;
    localparam int GainW   = 4;
    localparam int SpeedW  = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 8;

    // Signed product of gain and average, and the duty sum before clamping.
    localparam int ProdW = GainW + 1 + AvgW;
    localparam int RawW  = ProdW + 1;
    // Three times the average plus the position.
    localparam int SumW  = AvgW + 2;

    localparam logic signed [AvgW-1:0] W_OUTER = 7'sd32;
    localparam logic signed [AvgW-1:0] W_INNER = 7'sd8;

    localparam logic [CountW-1:0] LOST_LIMIT_RST   = 8'd5;
    localparam logic [SpeedW-1:0] CRUISE_SPEED_RST = 8'd32;
    localparam logic [GainW-1:0]  STEER_GAIN_RST   = 4'd2;

    localparam logic signed [RawW-1:0] DUTY_MAX = 13'sd255;

    typedef enum logic [CfgIdxW-1:0] {
        REG_LOST_LIMIT   = 2'd0,
        REG_CRUISE_SPEED = 2'd1,
        REG_STEER_GAIN   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CountW-1:0] lost_limit;
        logic [SpeedW-1:0] cruise_speed;
        logic [GainW-1:0]  steer_gain;
    } lfs_cfg_t;

    typedef struct packed {
        logic signed [AvgW-1:0] avg;
        logic [CountW-1:0]      miss;
    } lfs_state_t;

    // Packed so that left_duty, the last field declared, sits in the lowest bits.
    typedef struct packed {
        logic signed [AvgW-1:0] avg_position;
        logic                   line_lost;
        logic [DutyW-1:0]       right_duty;
        logic [DutyW-1:0]       left_duty;
    } lfs_result_t;

    function automatic logic [DutyW-1:0] clamp_duty(input logic signed [RawW-1:0] v);
        logic [DutyW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > DUTY_MAX)
            r = '1;
        else
            r = v[DutyW-1:0];
        return r;
    endfunction

endpackage

### rtl/core/lfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follow steering datapath
// Weighs one sensor sample, updates the running average and miss count, and
// forms the clamped motor duties. Purely combinational.
// ----------------------------------------------------------------------------
module lfs_datapath
    import lfs_pkg::*;
(
    input  logic [SensorW-1:0] sensor_bits,
    input  lfs_cfg_t           cfg,
    input  lfs_state_t         state,
    output lfs_state_t         state_next,
    output lfs_result_t        result
);

    logic signed [AvgW-1:0]  pos;
    logic signed [SumW-1:0]  avg_ext;
    logic signed [SumW-1:0]  sum;
    logic signed [SumW-1:0]  biased;
    logic signed [AvgW-1:0]  avg_new;
    logic [CountW-1:0]       miss_new;
    logic                    lost;
    logic signed [ProdW-1:0] prod;
    logic signed [RawW-1:0]  speed_ext;
    logic signed [RawW-1:0]  left_raw;
    logic signed [RawW-1:0]  right_raw;

    always_comb
    begin
        pos = '0;
        if (sensor_bits[0])
            pos = pos - W_OUTER;
        if (sensor_bits[1])
            pos = pos - W_INNER;
        if (sensor_bits[3])
            pos = pos + W_INNER;
        if (sensor_bits[4])
            pos = pos + W_OUTER;
    end

    // Division by four rounds toward zero, so a negative sum is biased first.
    assign avg_ext = SumW'(state.avg);
    assign sum     = (avg_ext <<< 1) + avg_ext + SumW'(pos);
    assign biased  = sum[SumW-1] ? sum + SumW'(3) : sum;
    assign avg_new = AvgW'(biased >>> 2);

    always_comb
    begin
        if (sensor_bits == '0)
        begin
            if (state.miss < cfg.lost_limit)
                miss_new = state.miss + 1'b1;
            else
                miss_new = state.miss;
        end
        else
        begin
            miss_new = '0;
        end
    end

    assign lost = (miss_new >= cfg.lost_limit);

    // Steer is the negated product, so left subtracts it and right adds it.
    assign prod      = ProdW'($signed({1'b0, cfg.steer_gain})) * ProdW'(avg_new);
    assign speed_ext = RawW'($signed({1'b0, cfg.cruise_speed}));
    assign left_raw  = speed_ext + RawW'(prod);
    assign right_raw = speed_ext - RawW'(prod);

    always_comb
    begin
        state_next.avg      = avg_new;
        state_next.miss     = miss_new;
        result.avg_position = avg_new;
        result.line_lost    = lost;
        if (lost || cfg.cruise_speed == '0)
        begin
            result.left_duty  = '0;
            result.right_duty = '0;
        end
        else
        begin
            result.left_duty  = clamp_duty(left_raw);
            result.right_duty = clamp_duty(right_raw);
        end
    end

endmodule

### rtl/core/line_follow_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follow steering
// Turns five reflectance bits per control tick into left and right motor
// duties from a running averaged line position, with line-lost detection.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_tvalid/s_tready   s_tdata: sensor_bits
//   m_       out        m_tvalid/m_tready   m_tdata: duties, lost, average
//   cfg_     in         cfg_we              cfg_index, cfg_data
//
// One request per cycle is sustained while the output is not stalled. An
// accepted request is held in the input register, and its result is shown
// from the result register, which loads when the output advances.
// The update loop of average and miss count closes through the state register.
// Reset clears the average, the count and both valid flags and loads the
// register defaults. A stalled output holds its result while the input
// register can still take one more request.
// ----------------------------------------------------------------------------
module line_follow_steering
    import lfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [4:0] sensor_bits, [7:5] zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // [7:0] left_duty, [15:8] right_duty,
                                          // [16] line_lost, [23:17] avg_position
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data
);

    lfs_cfg_t           cfg_reg;
    lfs_state_t         state_reg;
    lfs_state_t         state_next;
    logic               in_valid_reg;
    logic [SensorW-1:0] in_bits_reg;
    logic               out_valid_reg;
    lfs_result_t        out_reg;
    lfs_result_t        out_next;
    logic               advance;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lost_limit   <= LOST_LIMIT_RST;
            cfg_reg.cruise_speed <= CRUISE_SPEED_RST;
            cfg_reg.steer_gain   <= STEER_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOST_LIMIT:   cfg_reg.lost_limit   <= cfg_data[CountW-1:0];
                REG_CRUISE_SPEED: cfg_reg.cruise_speed <= cfg_data[SpeedW-1:0];
                REG_STEER_GAIN:   cfg_reg.steer_gain   <= cfg_data[GainW-1:0];
                default:          ;
            endcase
        end
    end

    lfs_datapath u_datapath (
        .sensor_bits (in_bits_reg),
        .cfg         (cfg_reg),
        .state       (state_reg),
        .state_next  (state_next),
        .result      (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (advance && in_valid_reg)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_bits_reg <= s_tdata[SensorW-1:0];
        if (advance && in_valid_reg)
            out_reg <= out_next;
    end

endmodule

### rtl/core/lfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follow steering checker
// Port-level properties of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module lfs_checker
    import lfs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output request changed while stalled");

    // A lost line drives both motors to zero.
    a_lost_stops: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[15:0] == 16'd0)
        else $error("duties not zero with line lost");

    // The average never leaves the span of the sensor weights.
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[23:17]) >= -7'sd40
                  && $signed(m_tdata[23:17]) <= 7'sd40)
        else $error("average position out of range");

    // With no result waiting the block must take a request.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind line_follow_steering lfs_checker u_lfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/line_follow_steering_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follow steering checker
// Watches the sensor, result and register write channels of the steering
// block. It keeps its own running average, miss count and register copies,
// works out the motor drive for every accepted request and compares each
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module line_follow_steering_checker
    import lfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // [4:0] sensor_bits, [7:5] zero
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [23:0]        m_tdata,   // [7:0] left_duty, [15:8] right_duty,
                                          // [16] line_lost, [23:17] avg_position
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_data,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int OuterWeight = 32;
    localparam int InnerWeight = 8;
    localparam int DutyCeiling = 255;

    int limit_est = 5;
    int speed_est = 32;
    int gain_est  = 2;
    int avg_est   = 0;
    int miss_est  = 0;

    int fail_tally    = 0;
    int outstanding_n = 0;

    lfs_result_t motor_drive_q[$];

    assign mismatches  = fail_tally;
    assign outstanding = outstanding_n;

    function automatic logic [DutyW-1:0] saturate_duty(input int v);
        logic [DutyW-1:0] d;
        if (v < 0)
            d = '0;
        else if (v > DutyCeiling)
            d = DutyCeiling[DutyW-1:0];
        else
            d = v[DutyW-1:0];
        return d;
    endfunction

    // Advances the average and miss count by one sample and returns the drive.
    function automatic lfs_result_t next_motor_drive(input logic [SensorW-1:0] bits);
        lfs_result_t r;
        int          pos;
        int          steer;
        logic        lost;
        pos = 0;
        if (bits[0])
            pos -= OuterWeight;
        if (bits[1])
            pos -= InnerWeight;
        if (bits[3])
            pos += InnerWeight;
        if (bits[4])
            pos += OuterWeight;

        // Integer division here truncates toward zero, as the average needs.
        avg_est = (3 * avg_est + pos) / 4;

        if (bits == '0)
        begin
            if (miss_est < limit_est)
                miss_est++;
        end
        else
            miss_est = 0;
        lost = (miss_est >= limit_est);

        r.left_duty  = '0;
        r.right_duty = '0;
        if (!lost && speed_est != 0)
        begin
            steer        = -gain_est * avg_est;
            r.left_duty  = saturate_duty(speed_est - steer);
            r.right_duty = saturate_duty(speed_est + steer);
        end
        r.line_lost    = lost;
        r.avg_position = avg_est[AvgW-1:0];
        return r;
    endfunction

    task automatic compare_drive(input lfs_result_t got);
        lfs_result_t want;
        if (motor_drive_q.size() == 0)
        begin
            $error("result %h arrived with no request outstanding", got);
            fail_tally++;
        end
        else
        begin
            want = motor_drive_q.pop_front();
            if (got.left_duty !== want.left_duty)
            begin
                $error("left_duty: expected %0d, got %0d", want.left_duty, got.left_duty);
                fail_tally++;
            end
            if (got.right_duty !== want.right_duty)
            begin
                $error("right_duty: expected %0d, got %0d", want.right_duty, got.right_duty);
                fail_tally++;
            end
            if (got.line_lost !== want.line_lost)
            begin
                $error("line_lost: expected %0b, got %0b", want.line_lost, got.line_lost);
                fail_tally++;
            end
            if (got.avg_position !== want.avg_position)
            begin
                $error("avg_position: expected %0d, got %0d",
                       $signed(want.avg_position), $signed(got.avg_position));
                fail_tally++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_est = 5;
            speed_est = 32;
            gain_est  = 2;
            avg_est   = 0;
            miss_est  = 0;
            motor_drive_q.delete();
            outstanding_n = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_drive(lfs_result_t'(m_tdata));
            if (s_tvalid && s_tready)
                motor_drive_q.push_back(next_motor_drive(s_tdata[SensorW-1:0]));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOST_LIMIT:   limit_est = cfg_data;
                    REG_CRUISE_SPEED: speed_est = cfg_data;
                    REG_STEER_GAIN:   gain_est  = cfg_data[GainW-1:0];
                    default:          ;
                endcase
            end
            outstanding_n = motor_drive_q.size();
        end
    end

endmodule

### test/line_follow_steering_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follow steering testbench
// Drives sensor samples and register writes into the steering block with
// random gaps and output stalls: a directed part covering the weights, line
// loss, zero speed, high gain and a lowered lost limit, then phases of line
// tracking traffic, empty runs and noise under random register settings.
// ----------------------------------------------------------------------------
module line_follow_steering_test
    import lfs_pkg::*;
();

    localparam int CycleLimit   = 200000;
    localparam int PhaseItems   = 100;
    localparam int PhaseCount   = 5;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0]    cfg_data;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   cur_limit   = 5;
    logic no_gaps     = 1'b0;

    line_follow_steering DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    line_follow_steering_checker steering_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The motor side stalls at random except during the steady stretch.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 21);
    end

    // Entered and left at a falling edge; holds the request until it is taken.
    task automatic send_sample(input logic [SensorW-1:0] bits);
        while (!no_gaps && $urandom_range(0, 99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, bits};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_config(input int limit, input int speed, input int gain);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOST_LIMIT;
        cfg_data  <= limit[CfgW-1:0];
        @(negedge clk);
        cfg_index <= REG_CRUISE_SPEED;
        cfg_data  <= speed[CfgW-1:0];
        @(negedge clk);
        cfg_index <= REG_STEER_GAIN;
        cfg_data  <= gain[CfgW-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_limit = limit;
        @(negedge clk);
    endtask

    // Mostly a line drifting under the sensors, with empty runs around the
    // lost limit and some random noise in between.
    task automatic run_traffic(input int n);
        int               sent;
        int               walk;
        int               run;
        int               k;
        int               span;
        logic [SensorW-1:0] pat;
        sent = 0;
        walk = $urandom_range(0, 8);
        while (sent < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    run = $urandom_range(1, 6);
                    for (k = 0; k < run; k++)
                    begin
                        walk += int'($urandom_range(0, 2)) - 1;
                        if (walk < 0)
                            walk = 0;
                        if (walk > 8)
                            walk = 8;
                        if (walk % 2 == 0)
                            pat = SensorW'(1 << (walk / 2));
                        else
                            pat = SensorW'(3 << (walk / 2));
                        send_sample(pat);
                        sent++;
                    end
                end
                6, 7:
                begin
                    span = (cur_limit > 12) ? 12 : cur_limit;
                    run  = $urandom_range(1, span + 2);
                    for (k = 0; k < run; k++)
                    begin
                        send_sample('0);
                        sent++;
                    end
                end
                default:
                begin
                    run = $urandom_range(1, 4);
                    for (k = 0; k < run; k++)
                    begin
                        send_sample(SensorW'($urandom_range(0, 31)));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        int phase;
        int limit;
        int speed;
        int gain;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LOST_LIMIT;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Register defaults: every weight, centre only, and the line lost.
        send_sample(5'b11111);
        send_sample(5'b00100);
        send_sample(5'b00001);
        send_sample(5'b00001);
        send_sample(5'b10000);
        send_sample(5'b10000);
        send_sample(5'b00010);
        send_sample(5'b01000);
        send_sample(5'b00011);
        send_sample(5'b11000);
        repeat (6) send_sample(5'b00000);
        send_sample(5'b00100);
        wait_drained();

        // Full speed with the highest gain, lost after a single empty reading.
        set_config(1, 255, 15);
        send_sample(5'b00001);
        send_sample(5'b10000);
        send_sample(5'b00000);
        wait_drained();

        // A zero lost limit keeps the line lost throughout.
        set_config(0, 100, 3);
        send_sample(5'b10000);
        send_sample(5'b00000);
        wait_drained();

        // Zero speed, then the limit lowered below the count already reached.
        set_config(255, 0, 8);
        send_sample(5'b10000);
        send_sample(5'b00001);
        repeat (4) send_sample(5'b00000);
        wait_drained();
        set_config(2, 0, 8);
        send_sample(5'b00000);
        send_sample(5'b10000);
        wait_drained();

        for (phase = 0; phase < PhaseCount; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       limit = 1;
                1:       limit = 255;
                default: limit = $urandom_range(2, 10);
            endcase
            case ($urandom_range(0, 5))
                0:       speed = 0;
                1:       speed = 255;
                default: speed = $urandom_range(1, 254);
            endcase
            case ($urandom_range(0, 5))
                0:       gain = 0;
                1:       gain = 15;
                default: gain = $urandom_range(1, 8);
            endcase
            set_config(limit, speed, gain);
            no_gaps = (phase == 2);
            run_traffic(PhaseItems);
            wait_drained();
            no_gaps = 1'b0;
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
